[rtl/espem_pkg.sv]
// Shared types and constants for the eco speed profile and energy meter.
// Used by espem_curve and eco_speed_profile_energy_meter_core; depends on nothing.
`default_nettype none

package espem_pkg;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int SPEED_W    = 10;
  localparam int STEP_W     = 8;
  localparam int FACTOR_W   = 15;
  localparam int POWER_W    = 25;
  localparam int ACC_OUT_W  = 48;
  localparam int RAMP_W     = 7;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  typedef logic [1:0]           mode_t;
  typedef logic [SPEED_W-1:0]   speed_t;
  typedef logic [RAMP_W-1:0]    ramp_t;

  localparam cfg_idx_t REG_DRIVE_MODE  = 2'd0;
  localparam cfg_idx_t REG_CURVE_SLOPE = 2'd1;

  localparam mode_t MODE_SPORT  = 2'd3;
  localparam mode_t MODE_NORMAL = 2'd2;

  localparam mode_t                 DRIVE_MODE_RST  = MODE_SPORT;
  localparam logic [CFG_DATA_W-1:0] CURVE_SLOPE_RST = 16'd9905;

  localparam speed_t SPORT_STRAIGHT  = 10'd1000;
  localparam speed_t SPORT_CURVE     = 10'd500;
  localparam speed_t NORMAL_STRAIGHT = 10'd700;
  localparam speed_t NORMAL_CURVE    = 10'd350;
  localparam speed_t ECO_STRAIGHT    = 10'd400;
  localparam speed_t ECO_CURVE       = 10'd200;
  localparam speed_t COAST_TARGET    = 10'd0;
  localparam speed_t IDLE_TARGET     = 10'd150;
  localparam speed_t COAST_ENTER     = 10'd390;
  localparam speed_t COAST_LEAVE     = 10'd320;
  localparam speed_t SPEED_MAX       = 10'd1000;

  localparam ramp_t RAMP_SPORT = 7'd80;
  localparam ramp_t RAMP_STD   = 7'd10;
  localparam ramp_t RAMP_SLOW  = 7'd5;

  localparam logic signed [FACTOR_W-1:0] DRAG_GAIN   = 15'sd150;
  localparam logic signed [FACTOR_W-1:0] ROLL_TERM   = 15'sd200;
  localparam logic signed [POWER_W-1:0]  BASE_POWER  = 25'sd10000;

endpackage

`default_nettype wire

[rtl/eco_speed_profile_energy_meter_core.sv]
// Top level: speed profile selection, ramped speed command and energy/distance meter.
// Depends on espem_pkg and espem_curve.
`default_nettype none

// Five-stage pipeline taking one transfer per clock cycle while out_tready does not
// stall it. Stage one registers the input, stage two classifies the curve (16x31
// multiply), stage three selects the target and steps the commanded speed (the
// speed/coasting feedback loop through speed_r and coast_r), stage four forms the
// power, and stage five adds it into the saturating accumulators held in the output
// register. Each stage has its own valid bit, so bubbles are absorbed while a result
// waits. Configuration is taken by the cfg_ port whenever cfg_wr_en is high.
module eco_speed_profile_energy_meter_core
  import espem_pkg::*;
#(
  parameter int ACC_WIDTH = 48
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [63:0]           in_tdata,   // target_x[31:0], target_y[63:32]
  input  wire logic                  in_tuser,   // has_target
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [135:0]               out_tdata,  // speed_cmd[9:0], power_cw[34:10],
                                                 // energy_total[82:35],
                                                 // distance_total[130:83], zero pad
  output logic [1:0]                 out_tuser   // curve_flag[0], coasting_flag[1]
);

  localparam logic signed [ACC_WIDTH-1:0] E_MAX = {1'b0, {(ACC_WIDTH-1){1'b1}}};
  localparam logic signed [ACC_WIDTH-1:0] E_MIN = {1'b1, {(ACC_WIDTH-1){1'b0}}};

  // configuration
  mode_t                 drive_mode_r;
  logic [CFG_DATA_W-1:0] curve_slope_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      drive_mode_r  <= DRIVE_MODE_RST;
      curve_slope_r <= CURVE_SLOPE_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_DRIVE_MODE:  drive_mode_r  <= cfg_wdata[1:0];
        REG_CURVE_SLOPE: curve_slope_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // stage valids and ready chain
  logic v1_r, v2_r, v3_r, v4_r, v5_r;
  logic rdy1, rdy2, rdy3, rdy4, rdy5;

  assign rdy5      = !v5_r || out_tready;
  assign rdy4      = !v4_r || rdy5;
  assign rdy3      = !v3_r || rdy4;
  assign rdy2      = !v2_r || rdy3;
  assign rdy1      = !v1_r || rdy2;
  assign in_tready = rdy1;

  // stage 1: input register
  logic               has1_r;
  logic signed [31:0] x1_r, y1_r;

  always_ff @(posedge clk) begin
    if (rdy1) begin
      has1_r <= in_tuser;
      x1_r   <= in_tdata[31:0];
      y1_r   <= in_tdata[63:32];
    end
  end

  // stage 2: curve classification
  logic curve_c;
  logic has2_r, curve2_r;

  espem_curve u_curve (
    .target_x    (x1_r),
    .target_y    (y1_r),
    .curve_slope (curve_slope_r),
    .curve       (curve_c)
  );

  always_ff @(posedge clk) begin
    if (rdy2) begin
      has2_r   <= has1_r;
      curve2_r <= has1_r && curve_c;
    end
  end

  // stage 3: target, ramp and speed step; speed_r/coast_r are the stage payload
  speed_t                       speed_r, speed_nxt;
  logic                         coast_r, coast_nxt;
  speed_t                       target;
  ramp_t                        ramp;
  logic signed [11:0]           diff, ramp_s;
  logic signed [STEP_W-1:0]     step;
  logic signed [FACTOR_W-1:0]   factor_nxt, factor3_r;
  logic                         curve3_r;
  logic                         fire2;

  assign fire2 = v2_r && rdy3;

  always_comb begin
    coast_nxt = coast_r;
    target    = IDLE_TARGET;
    ramp      = RAMP_SLOW;
    if (has2_r) begin
      if (drive_mode_r == MODE_SPORT) begin
        target = curve2_r ? SPORT_CURVE : SPORT_STRAIGHT;
        ramp   = RAMP_SPORT;
      end else if (drive_mode_r == MODE_NORMAL) begin
        target = curve2_r ? NORMAL_CURVE : NORMAL_STRAIGHT;
        ramp   = RAMP_STD;
      end else if (curve2_r) begin
        target    = ECO_CURVE;
        ramp      = RAMP_STD;
        coast_nxt = 1'b0;
      end else begin
        if (speed_r >= COAST_ENTER) begin
          coast_nxt = 1'b1;
        end else if (speed_r < COAST_LEAVE) begin
          coast_nxt = 1'b0;
        end
        target = coast_nxt ? COAST_TARGET : ECO_STRAIGHT;
        ramp   = coast_nxt ? RAMP_SLOW : RAMP_STD;
      end
    end
    diff   = $signed({2'b00, target}) - $signed({2'b00, speed_r});
    ramp_s = $signed({5'd0, ramp});
    if (diff > ramp_s) begin
      step = ramp_s[STEP_W-1:0];
    end else if (diff < -ramp_s) begin
      step = STEP_W'(-ramp_s);
    end else begin
      step = diff[STEP_W-1:0];
    end
    speed_nxt  = speed_r + speed_t'({{(SPEED_W-STEP_W){step[STEP_W-1]}}, step});
    factor_nxt = $signed({{(FACTOR_W-STEP_W){step[STEP_W-1]}}, step}) * DRAG_GAIN
                 + ROLL_TERM;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      speed_r <= '0;
      coast_r <= 1'b0;
    end else if (fire2) begin
      speed_r <= speed_nxt;
      coast_r <= coast_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire2) begin
      factor3_r <= factor_nxt;
      curve3_r  <= curve2_r;
    end
  end

  // stage 4: power
  logic signed [25:0]        prod;
  logic signed [POWER_W-1:0] power4_r;
  speed_t                    speed4_r;
  logic                      curve4_r, coast4_r;

  assign prod = factor3_r * $signed({1'b0, speed_r});

  always_ff @(posedge clk) begin
    if (rdy4) begin
      power4_r <= prod[POWER_W-1:0] + BASE_POWER;
      speed4_r <= speed_r;
      curve4_r <= curve3_r;
      coast4_r <= coast_r;
    end
  end

  // stage 5: saturating accumulators and output register
  logic signed [ACC_WIDTH-1:0] energy_acc_r, energy_nxt;
  logic [ACC_WIDTH-1:0]        dist_acc_r, dist_nxt;
  logic signed [ACC_WIDTH:0]   e_sum;
  logic [ACC_WIDTH:0]          d_sum;
  logic signed [POWER_W-1:0]   power5_r;
  speed_t                      speed5_r;
  logic                        curve5_r, coast5_r;
  logic                        fire4;

  assign fire4 = v4_r && rdy5;

  always_comb begin
    e_sum = {energy_acc_r[ACC_WIDTH-1], energy_acc_r}
            + {{(ACC_WIDTH+1-POWER_W){power4_r[POWER_W-1]}}, power4_r};
    if (e_sum[ACC_WIDTH] != e_sum[ACC_WIDTH-1]) begin
      energy_nxt = e_sum[ACC_WIDTH] ? E_MIN : E_MAX;
    end else begin
      energy_nxt = e_sum[ACC_WIDTH-1:0];
    end
    d_sum = {1'b0, dist_acc_r} + {{(ACC_WIDTH+1-SPEED_W){1'b0}}, speed4_r};
    dist_nxt = d_sum[ACC_WIDTH] ? {ACC_WIDTH{1'b1}} : d_sum[ACC_WIDTH-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      energy_acc_r <= '0;
      dist_acc_r   <= '0;
    end else if (fire4) begin
      energy_acc_r <= energy_nxt;
      dist_acc_r   <= dist_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire4) begin
      power5_r <= power4_r;
      speed5_r <= speed4_r;
      curve5_r <= curve4_r;
      coast5_r <= coast4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_tvalid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
      if (rdy5) v5_r <= v4_r;
    end
  end

  // output view of the accumulators
  logic [ACC_OUT_W-1:0] energy_out, dist_out;

  generate
    if (ACC_WIDTH >= ACC_OUT_W) begin : g_acc_wide
      assign energy_out = energy_acc_r[ACC_OUT_W-1:0];
      assign dist_out   = dist_acc_r[ACC_OUT_W-1:0];
    end else begin : g_acc_narrow
      assign energy_out = {{(ACC_OUT_W-ACC_WIDTH){energy_acc_r[ACC_WIDTH-1]}}, energy_acc_r};
      assign dist_out   = {{(ACC_OUT_W-ACC_WIDTH){1'b0}}, dist_acc_r};
    end
  endgenerate

  assign out_tvalid = v5_r;
  assign out_tdata  = {5'd0, dist_out, energy_out, power5_r, speed5_r};
  assign out_tuser  = {coast5_r, curve5_r};

  // checks
  a_speed_range: assert property (@(posedge clk) disable iff (!rst_n)
    speed_r <= SPEED_MAX)
    else $error("commanded speed out of range");

  a_coast_eco_only: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(coast_r) |-> ($past(drive_mode_r) != MODE_SPORT &&
                        $past(drive_mode_r) != MODE_NORMAL))
    else $error("coasting latch set outside eco mode");

  a_dist_monotone: assert property (@(posedge clk) disable iff (!rst_n)
    fire4 |=> dist_acc_r >= $past(dist_acc_r))
    else $error("distance accumulator decreased");

  a_acc_hold_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (v5_r && !out_tready) |=> ($stable(energy_acc_r) && $stable(dist_acc_r)))
    else $error("accumulators changed while result stalled");

endmodule

`default_nettype wire

[rtl/espem_curve.sv]
// Curve classifier: compares the target bearing against the slope threshold.
// Combinational; depends on espem_pkg.
`default_nettype none

module espem_curve
  import espem_pkg::*;
(
  input  wire logic signed [31:0]           target_x,
  input  wire logic signed [31:0]           target_y,
  input  wire logic [CFG_DATA_W-1:0]        curve_slope,
  output logic                              curve
);

  logic [31:0] abs_y;
  logic [47:0] lhs;
  logic [46:0] rhs;

  always_comb begin
    abs_y = target_y[31] ? (32'd0 - target_y) : target_y;
    lhs   = {abs_y, 16'd0};
    rhs   = curve_slope * target_x[30:0];
    if (target_x[31]) begin
      curve = 1'b1;
    end else if (target_x == 32'sd0) begin
      curve = (target_y != 32'sd0);
    end else begin
      curve = (lhs > {1'b0, rhs});
    end
  end

endmodule

`default_nettype wire

[verif/eco_speed_profile_energy_meter_core_tb.sv]
// Testbench for eco_speed_profile_energy_meter_core: random and directed control ticks,
// stalls on both stream sides, scoreboard class predicting speed, power and meters.
// Depends on espem_pkg and the core RTL.
`timescale 1ns / 100ps

module eco_speed_profile_energy_meter_core_tb;
  import espem_pkg::*;

  localparam cfg_idx_t REG_SPARE_2 = 2'd2;
  localparam cfg_idx_t REG_SPARE_3 = 2'd3;
  localparam mode_t MODE_ECO     = 2'd1;
  localparam mode_t MODE_ECO_ALT = 2'd0;
  localparam int CYCLE_LIMIT    = 1000000;
  localparam int DRAIN_CYCLES   = 10;
  localparam int RX_HOLD_CYCLES = 300;
  localparam int PHASES         = 10;
  localparam int PHASE_TICKS    = 200;

  typedef enum int {SEG_STRAIGHT, SEG_CURVE, SEG_NO_TARGET, SEG_NOISE} segment_t;

  typedef struct {
    logic [9:0]  speed_cmd;
    logic [24:0] power_cw;
    logic [47:0] energy_total;
    logic [47:0] distance_total;
    logic        curve_flag;
    logic        coasting_flag;
  } tick_result_t;

  class speed_energy_tracker;
    mode_t        mode;
    logic [15:0]  slope;
    int           speed;
    bit           coasting;
    longint       energy;
    longint       distance;
    tick_result_t pending[$];
    int           errors;

    function new();
      mode     = DRIVE_MODE_RST;
      slope    = CURVE_SLOPE_RST;
      speed    = 0;
      coasting = 0;
      energy   = 0;
      distance = 0;
      errors   = 0;
    endfunction

    function void set_reg(cfg_idx_t idx, logic [15:0] data);
      if (idx == REG_DRIVE_MODE) mode = data[1:0];
      else if (idx == REG_CURVE_SLOPE) slope = data;
    endfunction

    function bit classify_curve(logic signed [31:0] x, logic signed [31:0] y);
      longint sx;
      longint sy;
      longint ay;
      sx = x;
      sy = y;
      ay = (sy < 0) ? -sy : sy;
      if (sx > 0) return (ay <<< 16) > (longint'(slope) * sx);
      if (sx < 0) return 1'b1;
      return ay != 0;
    endfunction

    // one accepted tick: advance state, queue the result it produces
    function void note_tick(bit has, logic [31:0] x, logic [31:0] y);
      tick_result_t r;
      bit     curve;
      int     target;
      int     ramp;
      int     step;
      longint power;
      longint emax;
      longint dmax;
      emax  = (longint'(1) <<< 47) - 1;
      dmax  = (longint'(1) <<< 48) - 1;
      curve = 0;
      if (has) begin
        curve = classify_curve(x, y);
        if (mode == MODE_SPORT) begin
          target = curve ? SPORT_CURVE : SPORT_STRAIGHT;
          ramp   = RAMP_SPORT;
        end else if (mode == MODE_NORMAL) begin
          target = curve ? NORMAL_CURVE : NORMAL_STRAIGHT;
          ramp   = RAMP_STD;
        end else begin
          ramp = RAMP_STD;
          if (curve) begin
            target   = ECO_CURVE;
            coasting = 0;
          end else begin
            if (speed >= COAST_ENTER) coasting = 1;
            else if (speed < COAST_LEAVE) coasting = 0;
            if (coasting) begin
              target = COAST_TARGET;
              ramp   = RAMP_SLOW;
            end else begin
              target = ECO_STRAIGHT;
            end
          end
        end
      end else begin
        target = IDLE_TARGET;
        ramp   = RAMP_SLOW;
      end
      step = target - speed;
      if (step > ramp) step = ramp;
      if (step < -ramp) step = -ramp;
      speed += step;
      power = (150 * longint'(step) + 200) * speed + 10000;
      if (power > 0 && energy > emax - power) energy = emax;
      else if (power < 0 && energy < -emax - 1 - power) energy = -emax - 1;
      else energy += power;
      if (distance > dmax - speed) distance = dmax;
      else distance += speed;
      r.speed_cmd      = speed[9:0];
      r.power_cw       = power[24:0];
      r.energy_total   = energy[47:0];
      r.distance_total = distance[47:0];
      r.curve_flag     = curve;
      r.coasting_flag  = coasting;
      pending.push_back(r);
    endfunction

    function void compare_field(string name, logic [47:0] want, logic [47:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
      end
    endfunction

    function void check_tick(logic [135:0] d, logic [1:0] u);
      tick_result_t r;
      if (pending.size() == 0) begin
        errors++;
        $display("%0t: unexpected result transfer, actual %0h / %0h", $time, d, u);
        return;
      end
      r = pending.pop_front();
      compare_field("speed_cmd", r.speed_cmd, d[9:0]);
      compare_field("power_cw", r.power_cw, d[34:10]);
      compare_field("energy_total", r.energy_total, d[82:35]);
      compare_field("distance_total", r.distance_total, d[130:83]);
      compare_field("pad", 48'd0, d[135:131]);
      compare_field("curve_flag", r.curve_flag, u[0]);
      compare_field("coasting_flag", r.coasting_flag, u[1]);
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_wr_en;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [63:0]           in_tdata;   // target_x[31:0], target_y[63:32]
  logic                  in_tuser;   // has_target
  logic                  out_tvalid;
  logic                  out_tready;
  logic [135:0]          out_tdata;  // speed_cmd, power_cw, energy_total, distance_total
  logic [1:0]            out_tuser;  // curve_flag[0], coasting_flag[1]

  speed_energy_tracker tracker = new();
  bit tx_steady   = 0;
  bit rx_steady   = 0;
  bit rx_hold_req = 0;
  int cycle_count = 0;

  eco_speed_profile_energy_meter_core uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("eco_speed_profile_energy_meter_core: mismatch");
      $finish;
    end
  end

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  task automatic send_tick(bit has, logic [31:0] x, logic [31:0] y);
    int gap;
    in_tvalid <= 1'b1;
    in_tuser  <= has;
    in_tdata  <= {y, x};
    do @(posedge clk); while (in_tready !== 1'b1);
    tracker.note_tick(has, x, y);
    gap = tx_steady ? 0 : pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (tracker.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [15:0] data);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    tracker.set_reg(idx, data);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_mode(mode_t m);
    logic [15:0] data;
    data      = 16'($urandom);
    data[1:0] = m;
    write_reg(REG_DRIVE_MODE, data);
  endtask

  task automatic send_segment(segment_t kind, int len);
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] mag;
    repeat (len) begin
      case (kind)
        SEG_STRAIGHT: begin
          x = $urandom_range(1, 32'h7fffffff);
          if ($urandom_range(0, 1)) begin
            y = 0;
          end else begin
            mag = x >> (16 + $urandom_range(0, 8));
            y   = $urandom_range(0, 1) ? -mag : mag;
          end
          send_tick(1'b1, x, y);
        end
        SEG_CURVE: begin
          if ($urandom_range(0, 1)) begin
            x = {1'b1, 31'($urandom)};
            y = $urandom;
          end else begin
            x   = $urandom_range(1, 1 << 20);
            mag = $urandom_range(1 << 20, 32'h7fffffff);
            y   = $urandom_range(0, 1) ? -mag : mag;
          end
          send_tick(1'b1, x, y);
        end
        SEG_NO_TARGET: send_tick(1'b0, $urandom, $urandom);
        default:       send_tick(1'($urandom), $urandom, $urandom);
      endcase
    end
  endtask

  // result side: random stalls, one long hold-off on request
  initial begin
    int stall;
    stall = 0;
    out_tready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (out_tvalid === 1'b1 && out_tready === 1'b1) tracker.check_tick(out_tdata, out_tuser);
      if (rx_hold_req) begin
        rx_hold_req = 0;
        stall = RX_HOLD_CYCLES;
      end
      if (stall > 0) begin
        stall--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        if (!rx_steady) stall = pick_gap();
      end
    end
  end

  initial begin
    int       count;
    int       len;
    int       r;
    segment_t kind;
    mode_t    m;
    logic [15:0] slope;
    rst_n     <= 1'b0;
    cfg_wr_en <= 1'b0;
    cfg_index <= REG_DRIVE_MODE;
    cfg_wdata <= '0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: sport, default slope; geometry corners and the slope boundary
    send_tick(1'b0, 32'h0, 32'h0);
    send_tick(1'b1, 32'h0, 32'h0);
    send_tick(1'b1, 32'h0, 32'h1);
    send_tick(1'b1, 32'h0, 32'h80000000);
    send_tick(1'b1, 32'hffffffff, 32'h0);
    send_tick(1'b1, 32'h80000000, 32'h7fffffff);
    send_tick(1'b1, 32'h7fffffff, 32'h80000000);
    send_tick(1'b1, 32'h7fffffff, 32'h0);
    send_tick(1'b1, 32'd65536, 32'd9905);
    send_tick(1'b1, 32'd65536, 32'd9906);
    send_tick(1'b1, 32'd65536, -32'd9905);
    send_tick(1'b0, 32'hffffffff, 32'hffffffff);

    drain();
    set_mode(MODE_NORMAL);
    write_reg(REG_CURVE_SLOPE, 16'h0000);
    send_tick(1'b1, 32'd65536, 32'd1);
    send_tick(1'b1, 32'd65536, 32'd0);
    send_tick(1'b0, 32'd5, 32'd5);

    drain();
    set_mode(MODE_ECO_ALT);
    write_reg(REG_CURVE_SLOPE, 16'hffff);
    write_reg(REG_SPARE_2, 16'h0002);
    send_tick(1'b1, 32'd65536, 32'd65535);
    send_tick(1'b1, 32'd65536, 32'd65536);
    send_tick(1'b1, 32'd1, 32'hffffffff);
    send_tick(1'b0, 32'd0, 32'd0);

    drain();
    set_mode(MODE_ECO);
    write_reg(REG_SPARE_3, 16'hffff);
    send_tick(1'b1, 32'd100, 32'd0);
    send_tick(1'b1, -32'd100, 32'd0);

    for (int p = 0; p < PHASES; p++) begin
      drain();
      case (p % 4)
        0: m = MODE_ECO;
        1: m = MODE_SPORT;
        2: m = MODE_ECO_ALT;
        default: m = MODE_NORMAL;
      endcase
      if (p >= 4) m = mode_t'($urandom_range(0, 3));
      set_mode(m);
      r = $urandom_range(0, 3);
      slope = (r == 0) ? 16'h0000 : (r == 1) ? 16'hffff :
              (r == 2) ? CURVE_SLOPE_RST : 16'($urandom);
      write_reg(REG_CURVE_SLOPE, slope);
      write_reg($urandom_range(0, 1) ? REG_SPARE_2 : REG_SPARE_3, 16'($urandom));
      tx_steady = (p == 2 || p == 5);
      rx_steady = (p == 5);
      if (p == 2) rx_hold_req = 1;
      count = 0;
      while (count < PHASE_TICKS) begin
        r = $urandom_range(0, 9);
        if (r < 6) begin
          kind = SEG_STRAIGHT;
          len  = $urandom_range(1, 70);
        end else if (r < 8) begin
          kind = SEG_CURVE;
          len  = $urandom_range(1, 10);
        end else if (r < 9) begin
          kind = SEG_NO_TARGET;
          len  = $urandom_range(1, 10);
        end else begin
          kind = SEG_NOISE;
          len  = $urandom_range(1, 5);
        end
        send_segment(kind, len);
        count += len;
      end
    end

    drain();
    if (tracker.errors == 0 && tracker.pending.size() == 0) begin
      $display("eco_speed_profile_energy_meter_core: match");
    end else begin
      $display("eco_speed_profile_energy_meter_core: mismatch");
    end
    $finish;
  end

endmodule
